// ===== rtl/lowest_common_ancestor_lifting_assert.svh =====
// Assertion macros for the lowest common ancestor engine.
`ifndef LOWEST_COMMON_ANCESTOR_LIFTING_ASSERT_SVH
`define LOWEST_COMMON_ANCESTOR_LIFTING_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk, quiet during rst.
`define LCAL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, sampled on clk, quiet during rst.
`define LCAL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define LCAL_ASSERT_NOW(label, ante, cons, msg)
`define LCAL_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ===== rtl/lcal_pkg.sv =====
// Shared widths, defaults and request codes of the lowest common ancestor engine.
package lcal_pkg;

  localparam int NODE_W  = 10;
  localparam int COUNT_W = 11;
  localparam int REQ_W   = 2;

  localparam int MAX_NODES_DEF = 1024;
  localparam int LEVELS_DEF    = 10;

  localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd1024;

  localparam logic [REQ_W-1:0] REQ_LOAD  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_BUILD = 2'd1;
  localparam logic [REQ_W-1:0] REQ_QUERY = 2'd2;

endpackage

// ===== rtl/lowest_common_ancestor_lifting.sv =====
// Lowest common ancestor engine: ancestor table and depth store in synchronous memories.
// Load writes level 0 and the depth store. Build runs S_BLD_A, S_BLD_B, S_BLD_C per entry for
// levels 1 to LEVELS-1 over min(node_count, MAX_NODES) entries. Query reads both depths, lifts
//   the deeper node level by level, ends if the nodes meet, else climbs both and reads the parent.
// One item at a time; the result register lets the next item enter while a result waits.
// rst is synchronous: control and node_count (1024) reset; memories stay undefined.
module lowest_common_ancestor_lifting #(
  parameter int MAX_NODES = lcal_pkg::MAX_NODES_DEF,
  parameter int LEVELS    = lcal_pkg::LEVELS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr_en,
  input  logic [lcal_pkg::COUNT_W-1:0] cfg_wr_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [lcal_pkg::REQ_W-1:0]   req_type,
  input  logic [lcal_pkg::NODE_W-1:0]  node_a,
  input  logic [lcal_pkg::NODE_W-1:0]  node_b,
  input  logic [lcal_pkg::NODE_W-1:0]  node_depth,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [lcal_pkg::NODE_W-1:0]  ancestor
);
  import lcal_pkg::*;

  localparam int NODE_AW   = $clog2(MAX_NODES);
  localparam int LVL_W     = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int TBL_DEPTH = LEVELS * MAX_NODES;
  localparam int TBL_AW    = $clog2(TBL_DEPTH);
  localparam int CNT_W     = $clog2(MAX_NODES + 1);
  localparam int LIM_W     = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
  localparam logic [LVL_W-1:0] LVL_TOP = LVL_W'(LEVELS - 1);

  localparam int ST_W = 4;
  localparam logic [ST_W-1:0] S_IDLE  = 4'd0;
  localparam logic [ST_W-1:0] S_BLD_A = 4'd1;
  localparam logic [ST_W-1:0] S_BLD_B = 4'd2;
  localparam logic [ST_W-1:0] S_BLD_C = 4'd3;
  localparam logic [ST_W-1:0] S_Q_DB  = 4'd4;
  localparam logic [ST_W-1:0] S_Q_SW  = 4'd5;
  localparam logic [ST_W-1:0] S_Q_LFT = 4'd6;
  localparam logic [ST_W-1:0] S_Q_LT  = 4'd7;
  localparam logic [ST_W-1:0] S_Q_LD  = 4'd8;
  localparam logic [ST_W-1:0] S_Q_EQ  = 4'd9;
  localparam logic [ST_W-1:0] S_Q_CX  = 4'd10;
  localparam logic [ST_W-1:0] S_Q_CY  = 4'd11;
  localparam logic [ST_W-1:0] S_Q_CC  = 4'd12;
  localparam logic [ST_W-1:0] S_Q_FR  = 4'd13;
  localparam logic [ST_W-1:0] S_Q_OUT = 4'd14;

  // Reduce a node number to a store slot by constant compare and subtract.
  function automatic logic [NODE_AW-1:0] slot_of(input logic [NODE_W-1:0] n);
    logic [NODE_W-1:0] v;
    v = n;
    for (int k = NODE_W - 1; k >= 0; k--) begin
      if ((MAX_NODES << k) < (1 << NODE_W)) begin
        if (v >= NODE_W'(MAX_NODES << k)) begin
          v = v - NODE_W'(MAX_NODES << k);
        end
      end
    end
    return NODE_AW'(v);
  endfunction

  // Flatten a level and a slot into an ancestor table address.
  function automatic logic [TBL_AW-1:0] tbl_addr(input logic [LVL_W-1:0] l,
                                                  input logic [NODE_AW-1:0] s);
    return TBL_AW'(l) * TBL_AW'(MAX_NODES) + TBL_AW'(s);
  endfunction

  logic [NODE_W-1:0]  tbl_mem   [TBL_DEPTH];
  logic [NODE_W-1:0]  depth_mem [MAX_NODES];

  logic [COUNT_W-1:0] node_count;
  logic [ST_W-1:0]    state;
  logic [LVL_W-1:0]   lvl;
  logic [NODE_AW-1:0] bi;
  logic [NODE_W-1:0]  qx;
  logic [NODE_W-1:0]  qy;
  logic [NODE_W-1:0]  dx;
  logic [NODE_W-1:0]  dy;
  logic [NODE_W-1:0]  px;
  logic [NODE_W-1:0]  res;

  logic [NODE_W-1:0]  tbl_rd_data;
  logic [NODE_W-1:0]  dep_rd_data;
  logic [TBL_AW-1:0]  tbl_rd_addr;
  logic [NODE_AW-1:0] dep_rd_addr;
  logic               tbl_we;
  logic [TBL_AW-1:0]  tbl_wr_addr;
  logic [NODE_W-1:0]  tbl_wr_data;
  logic               dep_we;

  logic               in_acc;
  logic [CNT_W-1:0]   limit;
  logic               build_last;
  logic [NODE_W-1:0]  dep_gap;
  logic               lift_now;
  logic [NODE_W-1:0]  climb_x;

  assign in_ready = (state == S_IDLE);
  assign in_acc   = in_valid && in_ready;

  // Clamp the build range to the store size.
  assign limit = (LIM_W'(node_count) > LIM_W'(MAX_NODES)) ? CNT_W'(MAX_NODES)
                                                          : CNT_W'(node_count);
  assign build_last = ((CNT_W'(bi) + CNT_W'(1)) == limit);

  // Lift while the remaining depth gap covers this level's step.
  assign dep_gap  = dy - dx;
  assign lift_now = (dy >= dx) && ((dep_gap >> lvl) != '0);

  // Node x after the last climbing step.
  assign climb_x = (px != tbl_rd_data) ? px : qx;

  // Select the ancestor table read address.
  always_comb begin
    unique case (state)
      S_BLD_A: tbl_rd_addr = tbl_addr(lvl - LVL_W'(1), bi);
      S_BLD_B: tbl_rd_addr = tbl_addr(lvl - LVL_W'(1), slot_of(tbl_rd_data));
      S_Q_LFT: tbl_rd_addr = tbl_addr(lvl, slot_of(qy));
      S_Q_CY:  tbl_rd_addr = tbl_addr(lvl, slot_of(qy));
      S_Q_CC:  tbl_rd_addr = tbl_addr(LVL_W'(0), slot_of(climb_x));
      default: tbl_rd_addr = tbl_addr(lvl, slot_of(qx));
    endcase
  end

  // Select the depth store read address.
  always_comb begin
    unique case (state)
      S_IDLE:  dep_rd_addr = slot_of(node_a);
      S_Q_LT:  dep_rd_addr = slot_of(tbl_rd_data);
      default: dep_rd_addr = slot_of(qy);
    endcase
  end

  // Write level 0 on a load, higher levels during a build.
  always_comb begin
    tbl_we      = 1'b0;
    tbl_wr_addr = tbl_addr(LVL_W'(0), slot_of(node_a));
    tbl_wr_data = (node_a == '0) ? '0 : node_b;
    dep_we      = in_acc && (req_type == REQ_LOAD);
    if (in_acc && (req_type == REQ_LOAD)) begin
      tbl_we = 1'b1;
    end else if (state == S_BLD_C) begin
      tbl_we      = 1'b1;
      tbl_wr_addr = tbl_addr(lvl, bi);
      tbl_wr_data = tbl_rd_data;
    end
  end

  // Ancestor table memory.
  always_ff @(posedge clk) begin
    if (tbl_we) begin
      tbl_mem[tbl_wr_addr] <= tbl_wr_data;
    end
    tbl_rd_data <= tbl_mem[tbl_rd_addr];
  end

  // Depth store memory.
  always_ff @(posedge clk) begin
    if (dep_we) begin
      depth_mem[slot_of(node_a)] <= node_depth;
    end
    dep_rd_data <= depth_mem[dep_rd_addr];
  end

  // Hold the node count register.
  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= COUNT_RESET;
    end else if (cfg_wr_en) begin
      node_count <= cfg_wr_data;
    end
  end

  // Sequence builds and queries.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      lvl       <= '0;
      bi        <= '0;
      out_valid <= 1'b0;
    end else begin
      // Drop a taken result; a finishing query refills the register below.
      if (out_valid && out_ready && (state != S_Q_OUT)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            qx <= node_a;
            qy <= node_b;
            if (req_type == REQ_BUILD) begin
              if ((limit != '0) && (LEVELS > 1)) begin
                lvl   <= LVL_W'(1);
                bi    <= '0;
                state <= S_BLD_A;
              end
            end else if (req_type == REQ_QUERY) begin
              state <= S_Q_DB;
            end
          end
        end
        S_BLD_A: state <= S_BLD_B;
        S_BLD_B: state <= S_BLD_C;
        S_BLD_C: begin
          // Advance to the next entry, or the next level at the end of a row.
          if (build_last) begin
            bi <= '0;
            if (lvl == LVL_TOP) begin
              state <= S_IDLE;
            end else begin
              lvl   <= lvl + LVL_W'(1);
              state <= S_BLD_A;
            end
          end else begin
            bi    <= bi + NODE_AW'(1);
            state <= S_BLD_A;
          end
        end
        S_Q_DB: begin
          dx    <= dep_rd_data;
          state <= S_Q_SW;
        end
        S_Q_SW: begin
          // Keep the deeper node in y.
          if (dx > dep_rd_data) begin
            qx <= qy;
            qy <= qx;
            dy <= dx;
            dx <= dep_rd_data;
          end else begin
            dy <= dep_rd_data;
          end
          lvl   <= LVL_TOP;
          state <= S_Q_LFT;
        end
        S_Q_LFT: begin
          if (lift_now) begin
            state <= S_Q_LT;
          end else if (lvl == '0) begin
            state <= S_Q_EQ;
          end else begin
            lvl <= lvl - LVL_W'(1);
          end
        end
        S_Q_LT: begin
          qy    <= tbl_rd_data;
          state <= S_Q_LD;
        end
        S_Q_LD: begin
          dy <= dep_rd_data;
          if (lvl == '0) begin
            state <= S_Q_EQ;
          end else begin
            lvl   <= lvl - LVL_W'(1);
            state <= S_Q_LFT;
          end
        end
        S_Q_EQ: begin
          if (qx == qy) begin
            res   <= qx;
            state <= S_Q_OUT;
          end else begin
            lvl   <= LVL_TOP;
            state <= S_Q_CX;
          end
        end
        S_Q_CX: state <= S_Q_CY;
        S_Q_CY: begin
          px    <= tbl_rd_data;
          state <= S_Q_CC;
        end
        S_Q_CC: begin
          // Climb both nodes where their ancestors differ.
          if (px != tbl_rd_data) begin
            qx <= px;
            qy <= tbl_rd_data;
          end
          if (lvl == '0) begin
            state <= S_Q_FR;
          end else begin
            lvl   <= lvl - LVL_W'(1);
            state <= S_Q_CX;
          end
        end
        S_Q_FR: begin
          res   <= tbl_rd_data;
          state <= S_Q_OUT;
        end
        S_Q_OUT: begin
          if (!out_valid || out_ready) begin
            ancestor  <= res;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`include "lowest_common_ancestor_lifting_assert.svh"

  `LCAL_ASSERT_NEXT(a_query_starts, in_acc && (req_type == REQ_QUERY), state == S_Q_DB,
                    "query item did not start the depth reads")
  `LCAL_ASSERT_NEXT(a_result_lands, (state == S_Q_OUT) && (!out_valid || out_ready),
                    out_valid && (state == S_IDLE), "finished result was not presented")
  `LCAL_ASSERT_NOW(a_build_range, (state == S_BLD_A) || (state == S_BLD_B) || (state == S_BLD_C),
                   CNT_W'(bi) < limit, "build index ran past the node range")

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the binary lifting lowest common ancestor engine.
`timescale 1ns / 1ps

module tb;
  import lcal_pkg::*;

  localparam int LV = LEVELS_DEF;
  localparam int NN = MAX_NODES_DEF;
  localparam int CYCLE_LIMIT = 5_000_000;
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam logic [NODE_W-1:0] ROOT_NODE = '0;
  localparam logic [COUNT_W-1:0] DIR_COUNT = 11'd7;
  localparam logic [COUNT_W-1:0] COUNT_TOP = '1;

  typedef struct packed {
    logic [REQ_W-1:0]  req;
    logic [NODE_W-1:0] a;
    logic [NODE_W-1:0] b;
    logic [NODE_W-1:0] dep;
    logic              chk;
    logic [NODE_W-1:0] want;
  } stim_row_t;

  // Small tree: 0 root; 1, 2 under 0; 3, 4 under 1; 5 under 3; 6 under 2
  localparam int DIR_ROWS_N = 20;
  localparam stim_row_t DIR_ROWS [DIR_ROWS_N] = '{
    '{REQ_LOAD,   10'd0,    10'd1023, 10'd0,    1'b0, 10'd0},
    '{REQ_LOAD,   10'd1,    10'd0,    10'd1,    1'b0, 10'd0},
    '{REQ_LOAD,   10'd2,    10'd0,    10'd1,    1'b0, 10'd0},
    '{REQ_LOAD,   10'd3,    10'd1,    10'd2,    1'b0, 10'd0},
    '{REQ_LOAD,   10'd4,    10'd1,    10'd2,    1'b0, 10'd0},
    '{REQ_LOAD,   10'd5,    10'd3,    10'd3,    1'b0, 10'd0},
    '{REQ_LOAD,   10'd6,    10'd2,    10'd2,    1'b0, 10'd0},
    '{REQ_UNUSED, 10'd1023, 10'd1023, 10'd1023, 1'b0, 10'd0},
    '{REQ_BUILD,  10'd0,    10'd0,    10'd0,    1'b0, 10'd0},
    '{REQ_QUERY,  10'd5,    10'd4,    10'd0,    1'b1, 10'd1},
    '{REQ_QUERY,  10'd5,    10'd6,    10'd0,    1'b1, 10'd0},
    '{REQ_QUERY,  10'd3,    10'd3,    10'd0,    1'b1, 10'd3},
    '{REQ_QUERY,  10'd0,    10'd5,    10'd0,    1'b1, 10'd0},
    '{REQ_QUERY,  10'd5,    10'd3,    10'd0,    1'b1, 10'd3},
    '{REQ_QUERY,  10'd6,    10'd2,    10'd0,    1'b1, 10'd2},
    '{REQ_QUERY,  10'd1,    10'd2,    10'd0,    1'b1, 10'd0},
    '{REQ_LOAD,   10'd4,    10'd6,    10'd1023, 1'b0, 10'd0},
    '{REQ_QUERY,  10'd4,    10'd5,    10'd0,    1'b0, 10'd0},
    '{REQ_QUERY,  10'd6,    10'd4,    10'd0,    1'b0, 10'd0},
    '{REQ_QUERY,  10'd5,    10'd5,    10'd0,    1'b1, 10'd5}
  };

  logic                clk;
  logic                rst;
  logic                cfg_wr_en;
  logic [COUNT_W-1:0]  cfg_wr_data;
  logic                in_valid;
  logic                in_ready;
  logic [REQ_W-1:0]    req_type;
  logic [NODE_W-1:0]   node_a;
  logic [NODE_W-1:0]   node_b;
  logic [NODE_W-1:0]   node_depth;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [NODE_W-1:0]   ancestor;

  // Shadow of the engine: lifting table, depths and node count
  logic [NODE_W-1:0]   lift_tbl [LV][NN];
  logic [NODE_W-1:0]   depth_mem [NN];
  logic [COUNT_W-1:0]  node_cnt;

  logic [NODE_W-1:0]   ancestors_due [$];
  logic [NODE_W-1:0]   due_head;
  int                  errors = 0;
  int                  cycles = 0;
  int                  burst_left;
  int unsigned         rdy_left = 0;

  lowest_common_ancestor_lifting i_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .req_type   (req_type),
    .node_a     (node_a),
    .node_b     (node_b),
    .node_depth (node_depth),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .ancestor   (ancestor)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Clear the shadow state as after reset
  function automatic void clear_shadow();
    for (int j = 0; j < LV; j++) begin
      for (int i = 0; i < NN; i++) begin
        lift_tbl[j][i] = '0;
      end
    end
    for (int i = 0; i < NN; i++) begin
      depth_mem[i] = '0;
    end
    node_cnt = COUNT_RESET;
  endfunction

  // Fill every doubling level for the covered nodes
  function automatic void rebuild_levels();
    int lim;
    logic [NODE_W-1:0] mid;
    lim = (int'(node_cnt) > NN) ? NN : int'(node_cnt);
    for (int j = 1; j < LV; j++) begin
      for (int i = 0; i < lim; i++) begin
        mid = lift_tbl[j-1][i];
        lift_tbl[j][i] = lift_tbl[j-1][mid];
      end
    end
  endfunction

  // Lift the deeper node to equal depth, then climb both while they differ
  function automatic logic [NODE_W-1:0] lowest_common(input logic [NODE_W-1:0] xa,
                                                      input logic [NODE_W-1:0] ya);
    logic [NODE_W-1:0] x, y, t, px, py;
    int dx;
    x = xa;
    y = ya;
    if (depth_mem[x] > depth_mem[y]) begin
      t = x;
      x = y;
      y = t;
    end
    for (int k = LV - 1; k >= 0; k--) begin
      dx = int'(depth_mem[y]) - int'(depth_mem[x]);
      if (dx >= (1 << k)) y = lift_tbl[k][y];
    end
    if (x == y) return x;
    for (int k = LV - 1; k >= 0; k--) begin
      px = lift_tbl[k][x];
      py = lift_tbl[k][y];
      if (px != py) begin
        x = px;
        y = py;
      end
    end
    return lift_tbl[0][x];
  endfunction

  // Advance the shadow by one accepted item
  function automatic void track_item(input logic [REQ_W-1:0] r, input logic [NODE_W-1:0] a,
                                     input logic [NODE_W-1:0] b, input logic [NODE_W-1:0] d,
                                     output bit gives, output logic [NODE_W-1:0] res);
    gives = 1'b0;
    res = '0;
    case (r)
      REQ_LOAD: begin
        lift_tbl[0][a] = (a == ROOT_NODE) ? ROOT_NODE : b;
        depth_mem[a] = d;
      end
      REQ_BUILD: rebuild_levels();
      REQ_QUERY: begin
        gives = 1'b1;
        res = lowest_common(a, b);
      end
      default: ;
    endcase
  endfunction

  task automatic note_mismatch(input string what, input logic [NODE_W-1:0] got,
                               input logic [NODE_W-1:0] want);
    $display("tb: mismatch at cycle %0d: %s: got %0d, want %0d", cycles, what, got, want);
    errors++;
  endtask

  // Offer one item, hold it until taken, then log its expected result
  task automatic send_item(input logic [REQ_W-1:0] r, input logic [NODE_W-1:0] a,
                           input logic [NODE_W-1:0] b, input logic [NODE_W-1:0] d,
                           input bit typed, input logic [NODE_W-1:0] want);
    bit gives;
    logic [NODE_W-1:0] res;
    int gap;
    in_valid   <= 1'b1;
    req_type   <= r;
    node_a     <= a;
    node_b     <= b;
    node_depth <= d;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    track_item(r, a, b, d, gives, res);
    if (gives) ancestors_due = {ancestors_due, (typed ? want : res)};
    // Work in bursts with random gaps between them
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 10);
    end
  endtask

  task automatic send_query(input logic [NODE_W-1:0] a, input logic [NODE_W-1:0] b);
    send_item(REQ_QUERY, a, b, NODE_W'($urandom_range(0, NN - 1)), 1'b0, '0);
  endtask

  // Hold off until every result is back; each phase ends on a query
  task automatic settle_idle();
    in_valid <= 1'b0;
    while (ancestors_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_node_count(input logic [COUNT_W-1:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    node_cnt = v;
  endtask

  // Reload nodes 0..n-1 as a well-formed tree with parents below each node
  task automatic load_tree(input int n, input bit deep);
    int p;
    int off;
    send_item(REQ_LOAD, ROOT_NODE, NODE_W'($urandom_range(0, NN - 1)), '0, 1'b0, '0);
    for (int i = 1; i < n; i++) begin
      if (deep) begin
        off = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 1;
        p = (i > off) ? i - off : 0;
      end else begin
        p = $urandom_range(0, 1) ? i - 1 : $urandom_range(0, i - 1);
      end
      send_item(REQ_LOAD, NODE_W'(i), NODE_W'(p), depth_mem[p] + NODE_W'(1), 1'b0, '0);
    end
  endtask

  // Receiver stalls on a pattern of its own, with long ready stretches
  always @(posedge clk) begin
    if (rdy_left == 0) begin
      case ($urandom_range(0, 3))
        0: begin
          out_ready <= 1'b0;
          rdy_left  <= $urandom_range(1, 12);
        end
        1: begin
          out_ready <= 1'b1;
          rdy_left  <= $urandom_range(20, 60);
        end
        default: begin
          out_ready <= 1'($urandom_range(0, 1));
          rdy_left  <= $urandom_range(1, 4);
        end
      endcase
    end else begin
      rdy_left <= rdy_left - 1;
    end
  end

  // Compare each result with the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (ancestors_due.size() == 0) begin
        note_mismatch("result with nothing due", ancestor, '0);
      end else begin
        due_head = ancestors_due.pop_front();
        if (ancestor !== due_head) note_mismatch("ancestor", ancestor, due_head);
      end
    end
  end

  // Drop the run if it hangs
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    int tree_n;
    int pick;
    logic [NODE_W-1:0] qa;
    logic [NODE_W-1:0] qb;
    logic [COUNT_W-1:0] cnt;
    burst_left  = 0;
    rst         <= 1'b1;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    in_valid    <= 1'b0;
    req_type    <= REQ_LOAD;
    node_a      <= '0;
    node_b      <= '0;
    node_depth  <= '0;
    clear_shadow();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table on a seven node tree
    set_node_count(DIR_COUNT);
    for (int r = 0; r < DIR_ROWS_N; r++) begin
      send_item(DIR_ROWS[r].req, DIR_ROWS[r].a, DIR_ROWS[r].b, DIR_ROWS[r].dep,
                DIR_ROWS[r].chk, DIR_ROWS[r].want);
    end
    settle_idle();

    // Load every node as a deep tree and build with a count above the store size
    set_node_count(COUNT_TOP);
    load_tree(NN, 1'b1);
    send_item(REQ_BUILD, '0, '0, '0, 1'b0, '0);
    for (int q = 0; q < 60; q++) begin
      qa = NODE_W'($urandom_range(0, NN - 1));
      qb = (qa > 40) ? qa - NODE_W'($urandom_range(0, 40)) : NODE_W'($urandom_range(0, NN - 1));
      send_query(qa, qb);
    end
    send_query('1, '1);
    settle_idle();

    // Every entry is now written: small trees under several node counts, with noise
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: cnt = 11'd1;
        1: cnt = 11'd0;
        2: cnt = COUNT_RESET;
        default: cnt = COUNT_W'($urandom_range(2, 48));
      endcase
      set_node_count(cnt);
      tree_n = $urandom_range(2, 24);
      load_tree(tree_n, 1'b0);
      send_item(REQ_BUILD, '0, '0, '0, 1'b0, '0);
      for (int k = 0; k < 20; k++) begin
        pick = (k == 19) ? 19 : $urandom_range(0, 19);
        case (pick)
          0: send_item(REQ_UNUSED, NODE_W'($urandom), NODE_W'($urandom), NODE_W'($urandom),
                       1'b0, '0);
          1: send_item(REQ_BUILD, NODE_W'($urandom), NODE_W'($urandom), NODE_W'($urandom),
                       1'b0, '0);
          2, 3: send_item(REQ_LOAD, NODE_W'($urandom), NODE_W'($urandom), NODE_W'($urandom),
                          1'b0, '0);
          4, 5: send_query(NODE_W'($urandom), NODE_W'($urandom));
          default: send_query(NODE_W'($urandom_range(0, tree_n - 1)),
                              NODE_W'($urandom_range(0, tree_n - 1)));
        endcase
      end
      settle_idle();
    end

    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/lcal_pkg.sv
rtl/lowest_common_ancestor_lifting.sv
tb/tb.sv
